FILE: hw/rtl/lrbs_pkg.sv
// Shared types and constants for the largest remainder budget splitter.
package lrbs_pkg;

    localparam int TOT_W  = 24;
    localparam int WGT_W  = 20;
    localparam int ID_W   = 16;
    localparam int PRI_W  = 16;
    localparam int PROD_W = TOT_W + WGT_W;
    localparam int CFG_IDX_W = 1;

    localparam logic [WGT_W-1:0] WEIGHT_MAX = 20'd1024000;

    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR = 1'b1;

    typedef enum logic [1:0] {
        DIV_FLOOR,
        DIV_EVEN,
        DIV_SHARE
    } t_div_sel;

    typedef enum logic [3:0] {
        S_LOAD,
        S_FMUL,
        S_FCHK,
        S_FDIV,
        S_WCHK,
        S_EVDIV,
        S_MRD,
        S_MUL,
        S_DIVS,
        S_DWAIT,
        S_LEFT,
        S_KRD,
        S_KLAT,
        S_SWEEP,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic     load_we;
        logic     set_init;
        logic     fmul;
        logic     fok;
        logic     div_start;
        t_div_sel div_sel;
        logic     flr_from_div;
        logic     share_all_latch;
        logic     mult_en;
        logic     share_we;
        logic     left_en;
        logic     key_latch;
        logic     rank_clr;
        logic     rank_en;
        logic     j_is_i;
        logic     j_before_i;
        logic     emit;
        logic     last;
        logic     ovf;
        logic     set_clear;
    } t_cmd;

    typedef struct packed {
        logic fprod_gt;
        logic div_done;
        logic wsum_zero;
    } t_sts;

endpackage

FILE: hw/rtl/lrbs_div.sv
// Restoring divider, one quotient bit per cycle.
module lrbs_div #(
    parameter int DVD_W = 44,
    parameter int DVS_W = 26
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quo,
    output logic [DVS_W-1:0] o_rem
);

    localparam int CNT_W = (DVD_W > 1) ? $clog2(DVD_W) : 1;

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DVD_W-1:0] r_quo;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;
    logic [DVS_W:0]   w_shift;
    logic [DVS_W:0]   w_diff;
    logic             w_ge;

    assign w_shift = {r_rem, r_quo[DVD_W-1]};
    assign w_ge    = w_shift >= {1'b0, r_dvs};
    assign w_diff  = w_shift - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DVS_W-1:0] : w_shift[DVS_W-1:0];
            r_quo <= {r_quo[DVD_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule

FILE: hw/rtl/lrbs_dp.sv
// Datapath: config registers, entry stores, floor/share arithmetic, ranking, result registers.
module lrbs_dp #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [lrbs_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [lrbs_pkg::TOT_W-1:0]            i_cfg_data,
    input  logic [lrbs_pkg::ID_W-1:0]             i_entry_id,
    input  logic [lrbs_pkg::WGT_W-1:0]            i_weight,
    input  logic [lrbs_pkg::PRI_W-1:0]            i_priority_req,
    input  lrbs_pkg::t_cmd                        i_cmd,
    input  logic [$clog2(MAX_ENTRIES+1)-1:0]      i_count,
    input  logic [((MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1)-1:0] i_waddr,
    input  logic [((MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1)-1:0] i_raddr,
    output lrbs_pkg::t_sts                        o_sts,
    output logic                                  o_strobe,
    output logic [lrbs_pkg::ID_W-1:0]             o_out_id,
    output logic [lrbs_pkg::TOT_W-1:0]            o_budget,
    output logic [lrbs_pkg::TOT_W-1:0]            o_running_total,
    output logic                                  o_overflowed,
    output logic                                  o_last_result
);

    localparam int TOT_W  = lrbs_pkg::TOT_W;
    localparam int WGT_W  = lrbs_pkg::WGT_W;
    localparam int ID_W   = lrbs_pkg::ID_W;
    localparam int PRI_W  = lrbs_pkg::PRI_W;
    localparam int PROD_W = lrbs_pkg::PROD_W;
    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int SUM_W  = $clog2(MAX_ENTRIES * int'(lrbs_pkg::WEIGHT_MAX) + 1);
    localparam int FP_W   = TOT_W + CNT_W;
    localparam int KEY_W  = SUM_W + PRI_W + ID_W;

    logic [ID_W-1:0]  mem_id    [MAX_ENTRIES];
    logic [WGT_W-1:0] mem_wgt   [MAX_ENTRIES];
    logic [PRI_W-1:0] mem_pri   [MAX_ENTRIES];
    logic [TOT_W-1:0] mem_share [MAX_ENTRIES];
    logic [SUM_W-1:0] mem_rem   [MAX_ENTRIES];

    logic [ID_W-1:0]   r_rd_id;
    logic [WGT_W-1:0]  r_rd_wgt;
    logic [PRI_W-1:0]  r_rd_pri;
    logic [TOT_W-1:0]  r_rd_share;
    logic [SUM_W-1:0]  r_rd_rem;

    logic [TOT_W-1:0]  r_total;
    logic [TOT_W-1:0]  r_floor;
    logic [SUM_W-1:0]  r_wsum;
    logic [TOT_W-1:0]  r_flr;
    logic [FP_W-1:0]   r_fprod;
    logic [TOT_W-1:0]  r_remaining;
    logic [PROD_W-1:0] r_p;
    logic [TOT_W-1:0]  r_handed;
    logic [TOT_W-1:0]  r_leftover;
    logic [TOT_W-1:0]  r_share_all;
    logic [SUM_W-1:0]  r_key_rem;
    logic [PRI_W-1:0]  r_key_pri;
    logic [ID_W-1:0]   r_key_id;
    logic [TOT_W-1:0]  r_share_i;
    logic [CNT_W-1:0]  r_rank;
    logic [TOT_W-1:0]  r_running;

    logic              r_strobe;
    logic [ID_W-1:0]   r_out_id;
    logic [TOT_W-1:0]  r_budget;
    logic [TOT_W-1:0]  r_run_out;
    logic              r_ovf_out;
    logic              r_last_out;

    logic [WGT_W-1:0]  w_wsat;
    logic [PROD_W-1:0] w_dvd;
    logic [SUM_W-1:0]  w_dvs;
    logic              w_div_done;
    logic [PROD_W-1:0] w_quo;
    logic [SUM_W-1:0]  w_rem;
    logic [KEY_W-1:0]  w_key_j;
    logic [KEY_W-1:0]  w_key_i;
    logic              w_ahead;
    logic              w_bonus;
    logic [TOT_W-1:0]  w_budget;

    assign w_wsat = (i_weight > lrbs_pkg::WEIGHT_MAX) ? lrbs_pkg::WEIGHT_MAX : i_weight;

    always_comb begin
        case (i_cmd.div_sel)
            lrbs_pkg::DIV_FLOOR: begin
                w_dvd = PROD_W'(r_total);
                w_dvs = SUM_W'(i_count);
            end
            lrbs_pkg::DIV_EVEN: begin
                w_dvd = PROD_W'(r_remaining);
                w_dvs = SUM_W'(i_count);
            end
            default: begin
                w_dvd = r_p;
                w_dvs = r_wsum;
            end
        endcase
    end

    lrbs_div #(
        .DVD_W (PROD_W),
        .DVS_W (SUM_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_dvd),
        .i_divisor  (w_dvs),
        .o_done     (w_div_done),
        .o_quo      (w_quo),
        .o_rem      (w_rem)
    );

    // later entry in load order loses a tie; ~id so lower id ranks ahead
    assign w_key_j = {r_rd_rem, r_rd_pri, ~r_rd_id};
    assign w_key_i = {r_key_rem, r_key_pri, ~r_key_id};
    assign w_ahead = (w_key_j > w_key_i) || ((w_key_j == w_key_i) && i_cmd.j_before_i);

    assign w_bonus  = TOT_W'(r_rank) < r_leftover;
    assign w_budget = r_flr + r_share_i + TOT_W'(w_bonus);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_we) begin
            mem_id[i_waddr]  <= i_entry_id;
            mem_wgt[i_waddr] <= w_wsat;
            mem_pri[i_waddr] <= i_priority_req;
        end
        if (i_cmd.share_we) begin
            mem_share[i_waddr] <= w_quo[TOT_W-1:0];
            mem_rem[i_waddr]   <= w_rem;
        end
        r_rd_id    <= mem_id[i_raddr];
        r_rd_wgt   <= mem_wgt[i_raddr];
        r_rd_pri   <= mem_pri[i_raddr];
        r_rd_share <= mem_share[i_raddr];
        r_rd_rem   <= mem_rem[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total  <= '0;
            r_floor  <= '0;
            r_wsum   <= '0;
            r_strobe <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    lrbs_pkg::CFG_TOTAL: r_total <= i_cfg_data;
                    lrbs_pkg::CFG_FLOOR: r_floor <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.set_clear) begin
                r_wsum <= '0;
            end else if (i_cmd.load_we) begin
                r_wsum <= r_wsum + SUM_W'(w_wsat);
            end
            r_strobe <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.set_init) begin
            r_flr      <= r_floor;
            r_running  <= '0;
            r_leftover <= '0;
        end
        if (i_cmd.fmul) begin
            r_fprod <= FP_W'(r_flr) * FP_W'(i_count);
        end
        if (i_cmd.fok) begin
            r_remaining <= r_total - r_fprod[TOT_W-1:0];
            r_handed    <= '0;
        end
        if (i_cmd.flr_from_div) begin
            r_flr <= w_quo[TOT_W-1:0];
        end
        if (i_cmd.share_all_latch) begin
            r_share_all <= w_quo[TOT_W-1:0];
        end
        if (i_cmd.mult_en) begin
            r_p <= PROD_W'(r_remaining) * PROD_W'(r_rd_wgt);
        end
        if (i_cmd.share_we) begin
            r_handed <= r_handed + w_quo[TOT_W-1:0];
        end
        if (i_cmd.left_en) begin
            r_leftover <= r_remaining - r_handed;
        end
        if (i_cmd.key_latch) begin
            r_key_rem <= r_rd_rem;
            r_key_pri <= r_rd_pri;
            r_key_id  <= r_rd_id;
            r_share_i <= (r_wsum == '0) ? r_share_all : r_rd_share;
        end
        if (i_cmd.rank_clr) begin
            r_rank <= '0;
        end else if (i_cmd.rank_en && w_ahead && !i_cmd.j_is_i) begin
            r_rank <= r_rank + 1'b1;
        end
        if (i_cmd.emit) begin
            r_running  <= r_running + w_budget;
            r_out_id   <= r_key_id;
            r_budget   <= w_budget;
            r_run_out  <= r_running + w_budget;
            r_ovf_out  <= i_cmd.ovf;
            r_last_out <= i_cmd.last;
        end
    end

    assign o_sts.fprod_gt  = r_fprod > FP_W'(r_total);
    assign o_sts.div_done  = w_div_done;
    assign o_sts.wsum_zero = (r_wsum == '0);

    assign o_strobe        = r_strobe;
    assign o_out_id        = r_out_id;
    assign o_budget        = r_budget;
    assign o_running_total = r_run_out;
    assign o_overflowed    = r_ovf_out;
    assign o_last_result   = r_last_out;

endmodule

FILE: hw/rtl/lrbs_ctrl.sv
// Controller: load counting, split sequencing, rank sweep and result emission.
module lrbs_ctrl #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic                                  i_last_entry,
    input  lrbs_pkg::t_sts                        i_sts,
    output logic                                  o_busy,
    output lrbs_pkg::t_cmd                        o_cmd,
    output logic [$clog2(MAX_ENTRIES+1)-1:0]      o_count,
    output logic [((MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1)-1:0] o_waddr,
    output logic [((MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1)-1:0] o_raddr
);

    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int ADDR_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    lrbs_pkg::t_state r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_flag, n_flag;
    logic [ADDR_W-1:0] r_i, n_i;
    logic [ADDR_W-1:0] r_j, n_j;
    logic [ADDR_W-1:0] w_nlast;

    assign w_nlast = ADDR_W'(r_count - 1'b1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lrbs_pkg::S_LOAD;
            r_count <= '0;
            r_flag  <= 1'b0;
            r_i     <= '0;
            r_j     <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_flag  <= n_flag;
            r_i     <= n_i;
            r_j     <= n_j;
        end
    end

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_flag  = r_flag;
        n_i     = r_i;
        n_j     = r_j;
        o_cmd   = '0;
        o_cmd.div_sel = lrbs_pkg::DIV_SHARE;
        o_waddr = r_i;
        o_raddr = r_i;
        case (r_state)
            lrbs_pkg::S_LOAD: begin
                o_waddr = ADDR_W'(r_count);
                if (i_start) begin
                    if (r_count < CNT_W'(MAX_ENTRIES)) begin
                        o_cmd.load_we = 1'b1;
                        n_count = r_count + 1'b1;
                    end else begin
                        n_flag = 1'b1;
                    end
                    if (i_last_entry) begin
                        o_cmd.set_init = 1'b1;
                        n_state = lrbs_pkg::S_FMUL;
                    end
                end
            end
            lrbs_pkg::S_FMUL: begin
                o_cmd.fmul = 1'b1;
                n_state = lrbs_pkg::S_FCHK;
            end
            lrbs_pkg::S_FCHK: begin
                if (i_sts.fprod_gt) begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = lrbs_pkg::DIV_FLOOR;
                    n_state = lrbs_pkg::S_FDIV;
                end else begin
                    o_cmd.fok = 1'b1;
                    n_state = lrbs_pkg::S_WCHK;
                end
            end
            lrbs_pkg::S_FDIV: begin
                if (i_sts.div_done) begin
                    o_cmd.flr_from_div = 1'b1;
                    n_state = lrbs_pkg::S_FMUL;
                end
            end
            lrbs_pkg::S_WCHK: begin
                n_i = '0;
                if (i_sts.wsum_zero) begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = lrbs_pkg::DIV_EVEN;
                    n_state = lrbs_pkg::S_EVDIV;
                end else begin
                    n_state = lrbs_pkg::S_MRD;
                end
            end
            lrbs_pkg::S_EVDIV: begin
                if (i_sts.div_done) begin
                    o_cmd.share_all_latch = 1'b1;
                    n_i = '0;
                    n_state = lrbs_pkg::S_KRD;
                end
            end
            lrbs_pkg::S_MRD: begin
                n_state = lrbs_pkg::S_MUL;
            end
            lrbs_pkg::S_MUL: begin
                o_cmd.mult_en = 1'b1;
                n_state = lrbs_pkg::S_DIVS;
            end
            lrbs_pkg::S_DIVS: begin
                o_cmd.div_start = 1'b1;
                n_state = lrbs_pkg::S_DWAIT;
            end
            lrbs_pkg::S_DWAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.share_we = 1'b1;
                    if (r_i == w_nlast) begin
                        n_state = lrbs_pkg::S_LEFT;
                    end else begin
                        n_i = r_i + 1'b1;
                        n_state = lrbs_pkg::S_MRD;
                    end
                end
            end
            lrbs_pkg::S_LEFT: begin
                o_cmd.left_en = 1'b1;
                n_i = '0;
                n_state = lrbs_pkg::S_KRD;
            end
            lrbs_pkg::S_KRD: begin
                n_state = lrbs_pkg::S_KLAT;
            end
            lrbs_pkg::S_KLAT: begin
                o_cmd.key_latch = 1'b1;
                o_cmd.rank_clr  = 1'b1;
                o_raddr = '0;
                n_j = '0;
                n_state = i_sts.wsum_zero ? lrbs_pkg::S_EMIT : lrbs_pkg::S_SWEEP;
            end
            lrbs_pkg::S_SWEEP: begin
                o_raddr = r_j + 1'b1;
                o_cmd.rank_en    = 1'b1;
                o_cmd.j_is_i     = (r_j == r_i);
                o_cmd.j_before_i = (r_j < r_i);
                if (r_j == w_nlast) begin
                    n_state = lrbs_pkg::S_EMIT;
                end else begin
                    n_j = r_j + 1'b1;
                end
            end
            lrbs_pkg::S_EMIT: begin
                o_cmd.emit = 1'b1;
                o_cmd.ovf  = r_flag;
                o_cmd.last = (r_i == w_nlast);
                if (r_i == w_nlast) begin
                    o_cmd.set_clear = 1'b1;
                    n_count = '0;
                    n_flag  = 1'b0;
                    n_state = lrbs_pkg::S_LOAD;
                end else begin
                    n_i = r_i + 1'b1;
                    n_state = lrbs_pkg::S_KRD;
                end
            end
            default: begin
                n_state = lrbs_pkg::S_LOAD;
            end
        endcase
    end

    assign o_busy  = (r_state != lrbs_pkg::S_LOAD);
    assign o_count = r_count;

endmodule

FILE: hw/rtl/largest_remainder_budget_split_core.sv
// Largest remainder budget splitter top level.
// Entries load one per cycle while busy is low; the entry with last_entry set
// starts the split and raises busy. The split cuts the floor by a divide
// when floor times count exceeds the total; then it divides out each share,
// one bit-serial divide per entry, all through one shared divider (one even
// divide if all weights are zero), then ranks each entry against the set
// through the single read port of the entry store (not when all weights are
// zero). Results come out in load order with o_strobe high for one cycle
// each and cannot be held off; busy drops on the cycle of the last result.
module largest_remainder_budget_split_core #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [lrbs_pkg::ID_W-1:0]           i_entry_id,
    input  logic [lrbs_pkg::WGT_W-1:0]          i_weight,
    input  logic [lrbs_pkg::PRI_W-1:0]          i_priority_req,
    input  logic                                i_last_entry,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [lrbs_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [lrbs_pkg::TOT_W-1:0]          i_cfg_data,
    output logic                                o_strobe,
    output logic [lrbs_pkg::ID_W-1:0]           o_out_id,
    output logic [lrbs_pkg::TOT_W-1:0]          o_budget,
    output logic [lrbs_pkg::TOT_W-1:0]          o_running_total,
    output logic                                o_overflowed,
    output logic                                o_last_result
);

    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int ADDR_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    lrbs_pkg::t_cmd    w_cmd;
    lrbs_pkg::t_sts    w_sts;
    logic [CNT_W-1:0]  w_count;
    logic [ADDR_W-1:0] w_waddr;
    logic [ADDR_W-1:0] w_raddr;

    assign o_cfg_ready = 1'b1;

    lrbs_ctrl #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_last_entry (i_last_entry),
        .i_sts        (w_sts),
        .o_busy       (busy),
        .o_cmd        (w_cmd),
        .o_count      (w_count),
        .o_waddr      (w_waddr),
        .o_raddr      (w_raddr)
    );

    lrbs_dp #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_valid && o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_entry_id      (i_entry_id),
        .i_weight        (i_weight),
        .i_priority_req  (i_priority_req),
        .i_cmd           (w_cmd),
        .i_count         (w_count),
        .i_waddr         (w_waddr),
        .i_raddr         (w_raddr),
        .o_sts           (w_sts),
        .o_strobe        (o_strobe),
        .o_out_id        (o_out_id),
        .o_budget        (o_budget),
        .o_running_total (o_running_total),
        .o_overflowed    (o_overflowed),
        .o_last_result   (o_last_result)
    );

    a_last_starts_split: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_last_entry |=> busy)
        else $error("split did not start after last entry");

    a_mid_result_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_last_result |-> busy)
        else $error("result before last while not busy");

    a_last_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_last_result |-> !busy)
        else $error("still busy on last result");

    a_results_spaced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("back to back result strobes");

endmodule
